// ===== rtl/hidrd_pkg.sv =====
`default_nettype none
package hidrd_pkg;
  localparam logic [2:0] KIND_SUMMARY = 3'd0;
  localparam logic [2:0] KIND_BUTTON  = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNBALANCED = 3'd1;
  localparam logic [2:0] ST_BAD_MAIN   = 3'd2;
  localparam logic [2:0] ST_BAD_GLOBAL = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  localparam logic [1:0] CLS_NONE     = 2'd0;
  localparam logic [1:0] CLS_KEYBOARD = 2'd1;
  localparam logic [1:0] CLS_MOUSE    = 2'd2;
  localparam logic [1:0] CLS_JOYSTICK = 2'd3;

  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  localparam logic [3:0] TAG_INPUT    = 4'd8;
  localparam logic [3:0] TAG_OUTPUT   = 4'd9;
  localparam logic [3:0] TAG_COLL     = 4'd10;
  localparam logic [3:0] TAG_FEATURE  = 4'd11;
  localparam logic [3:0] TAG_END_COLL = 4'd12;

  localparam logic [3:0] TAG_LMIN   = 4'd1;
  localparam logic [3:0] TAG_LMAX   = 4'd2;
  localparam logic [3:0] TAG_RSIZE  = 4'd7;
  localparam logic [3:0] TAG_RID    = 4'd8;
  localparam logic [3:0] TAG_RCOUNT = 4'd9;

  localparam logic [3:0] TAG_USAGE = 4'd0;
  localparam logic [3:0] TAG_UMIN  = 4'd1;
  localparam logic [3:0] TAG_UMAX  = 4'd2;

  localparam logic [7:0] USAGE_X     = 8'd48;
  localparam logic [7:0] USAGE_Y     = 8'd49;
  localparam logic [7:0] USAGE_WHEEL = 8'd56;
  localparam logic [7:0] USAGE_HAT   = 8'd57;

  localparam logic [3:0] FL_X  = 4'h1;
  localparam logic [3:0] FL_Y  = 4'h2;
  localparam logic [3:0] FL_B0 = 4'h4;
  localparam logic [3:0] FL_B1 = 4'h8;

  localparam logic [7:0]  NO_SLOT = 8'hFF;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef struct packed {
    logic        valid;
    logic [15:0] offset;
    logic [7:0]  size;
    logic [15:0] lmin;
    logic [15:0] lmax;
  } field_rec_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] byte_pos;
    logic [7:0]  len;
    logic [1:0]  cls;
    logic [7:0]  rid;
    logic [7:0]  btotal;
    logic [8:0]  err;
  } summary_t;
endpackage
`default_nettype wire

// ===== rtl/hid_report_descriptor_parser.sv =====
`default_nettype none
// channel  signals                                       dir
// in       in_valid/in_ready, desc_byte, last            sink
// out      out_valid/out_ready, record_kind..last_record source
// one descriptor byte per cycle while no record run is in progress
// a stop starts a run of 1 + located fields + button records, one per cycle
// while out_ready is high, during which input is held off
// rst is synchronous and returns the parser to its idle state
// out_ready low stalls the record run only
module hid_report_descriptor_parser #(
  parameter int BUTTONS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  desc_byte,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       record_kind,
  output logic [3:0]       button_index,
  output logic [15:0]      bit_offset,
  output logic [7:0]       field_size,
  output logic [15:0]      logical_min,
  output logic [15:0]      logical_max,
  output logic [2:0]       status,
  output logic [1:0]       device_type,
  output logic [7:0]       rep_id,
  output logic [7:0]       button_bits,
  output logic [8:0]       error_item,
  output logic             last_record
);
  import hidrd_pkg::*;

  logic        in_phase;
  logic [5:0]  hdr;
  logic [2:0]  left;
  logic [1:0]  have;
  logic [31:0] pval;
  logic [7:0]  app_d, pl_d, skip_d, nest_d;
  logic [7:0]  rsize, rcount;
  logic [15:0] bits, uidx, lmin, lmax;
  logic [3:0]  flags;
  logic [3:0][7:0] slots;
  logic [1:0]  cls;
  logic [7:0]  rid, btotal;
  field_rec_t [3:0] recs;
  logic [BUTTONS-1:0] bval;
  logic [BUTTONS-1:0][15:0] bpos;
  logic [15:0] bytepos;
  logic        fin;

  logic        in_phase_next;
  logic [5:0]  hdr_next;
  logic [2:0]  left_next;
  logic [1:0]  have_next;
  logic [31:0] pval_next;
  logic [7:0]  app_d_next, pl_d_next, skip_d_next, nest_d_next;
  logic [7:0]  rsize_next, rcount_next;
  logic [15:0] bits_next, uidx_next, lmin_next, lmax_next;
  logic [3:0]  flags_next;
  logic [3:0][7:0] slots_next;
  logic [1:0]  cls_next;
  logic [7:0]  rid_next, btotal_next;
  field_rec_t [3:0] recs_next;
  logic [BUTTONS-1:0] bval_next;
  logic [BUTTONS-1:0][15:0] bpos_next;
  logic [15:0] bytepos_next;
  logic        fin_next;

  logic        busy, accept, exec, stop;
  logic [2:0]  st;
  logic [8:0]  err;
  logic [1:0]  itype;
  logic [3:0]  itag;
  logic [31:0] v;
  logic [15:0] prod;
  logic [16:0] lenb;
  summary_t    summ;

  assign in_ready = !busy;
  assign accept = in_valid && in_ready;
  assign prod = 16'(rcount) * 16'(rsize);

  function automatic logic is_usable(input logic [1:0] c, input logic [3:0] f);
    case (c)
      CLS_KEYBOARD: is_usable = 1'b1;
      CLS_JOYSTICK: is_usable = (f[2:0] == 3'h7);
      CLS_MOUSE:    is_usable = (f == 4'hF);
      default:      is_usable = 1'b0;
    endcase
  endfunction

  always_comb begin
    in_phase_next = in_phase; hdr_next = hdr; left_next = left; have_next = have;
    pval_next = pval; app_d_next = app_d; pl_d_next = pl_d; skip_d_next = skip_d;
    nest_d_next = nest_d; rsize_next = rsize; rcount_next = rcount; bits_next = bits;
    uidx_next = uidx; lmin_next = lmin; lmax_next = lmax; flags_next = flags;
    slots_next = slots; cls_next = cls; rid_next = rid; btotal_next = btotal;
    recs_next = recs; bval_next = bval; bpos_next = bpos; bytepos_next = bytepos;
    fin_next = fin;
    exec = 1'b0; stop = 1'b0; st = ST_OK; err = '0;
    itype = '0; itag = '0; v = '0;

    if (bytepos != POS_MAX) bytepos_next = bytepos + 16'd1;
    if (!in_phase) begin
      hdr_next = desc_byte[7:2];
      have_next = '0;
      left_next = (desc_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, desc_byte[1:0]};
      itype = desc_byte[3:2]; itag = desc_byte[7:4];
      if (desc_byte[1:0] == 2'd0) exec = 1'b1;
      else in_phase_next = 1'b1;
      pval_next = '0;
    end else begin
      itype = hdr[1:0]; itag = hdr[5:2];
      v = pval | (32'(desc_byte) << {have, 3'b000});
      pval_next = v;
      have_next = have + 2'd1;
      left_next = left - 3'd1;
      if (left == 3'd1) begin
        in_phase_next = 1'b0;
        exec = 1'b1;
      end
    end

    if (exec) begin
      if (skip_d != 8'd0) begin
        if (itype == TYPE_MAIN && itag == TAG_COLL) begin
          skip_d_next = skip_d + 8'd1; nest_d_next = nest_d + 8'd1;
        end else if (itype == TYPE_MAIN && itag == TAG_END_COLL) begin
          skip_d_next = skip_d - 8'd1; nest_d_next = nest_d - 8'd1;
        end
      end else begin
        case (itype)
          TYPE_MAIN: begin
            case (itag)
              TAG_INPUT: begin
                for (int b = 0; b < BUTTONS; b++) begin
                  if (32'(b) < 32'(rcount)) begin
                    bval_next[b] = 1'b1;
                    bpos_next[b] = bits + 16'(b);
                  end
                end
                btotal_next = prod[7:0];
                if (prod[7:0] > 8'd0) flags_next = flags_next | FL_B0;
                if (prod[7:0] > 8'd1) flags_next = flags_next | FL_B1;
                for (int c = 0; c < 4; c++) begin
                  if (slots[c] < 8'd128 && !(c == 2 && cls != CLS_JOYSTICK)
                      && !(c == 3 && cls != CLS_MOUSE)) begin
                    recs_next[c].valid = 1'b1;
                    recs_next[c].offset = bits + 16'(rsize) * 16'(slots[c]);
                    recs_next[c].size = rsize;
                    recs_next[c].lmin = (c == 2) ? 16'd0 : lmin;
                    recs_next[c].lmax = (c == 2) ? 16'd0 : lmax;
                    if (c == 0) flags_next = flags_next | FL_X;
                    if (c == 1) flags_next = flags_next | FL_Y;
                  end
                end
                bits_next = bits + prod;
                uidx_next = '0;
                slots_next = {4{NO_SLOT}};
              end
              TAG_OUTPUT, TAG_FEATURE: ;
              TAG_COLL: begin
                nest_d_next = nest_d + 8'd1;
                uidx_next = '0;
                if (v == 32'd1) app_d_next = app_d + 8'd1;
                else if (v == 32'd0 || v == 32'd2) pl_d_next = pl_d + 8'd1;
                else skip_d_next = skip_d + 8'd1;
              end
              TAG_END_COLL: begin
                nest_d_next = nest_d - 8'd1;
                if (pl_d != 8'd0) pl_d_next = pl_d - 8'd1;
                else if (app_d != 8'd0) begin
                  app_d_next = app_d - 8'd1;
                  if (is_usable(cls, flags)) begin
                    stop = 1'b1; st = ST_OK;
                  end else begin
                    bits_next = '0; flags_next = '0; cls_next = CLS_NONE;
                  end
                end else begin
                  stop = 1'b1; st = ST_UNBALANCED;
                end
              end
              default: begin
                stop = 1'b1; st = ST_BAD_MAIN; err = {5'd0, itag};
              end
            endcase
          end
          TYPE_GLOBAL: begin
            case (itag)
              TAG_LMIN:   lmin_next = v[15:0];
              TAG_LMAX:   lmax_next = v[15:0];
              TAG_RSIZE:  rsize_next = v[7:0];
              TAG_RID:    rid_next = v[7:0];
              TAG_RCOUNT: rcount_next = v[7:0];
              default: begin
                if (itag > TAG_RCOUNT) begin
                  stop = 1'b1; st = ST_BAD_GLOBAL; err = {5'b10000, itag};
                end
              end
            endcase
          end
          TYPE_LOCAL: begin
            case (itag)
              TAG_USAGE: begin
                if (nest_d == 8'd0) begin
                  if (v == 32'd6) cls_next = CLS_KEYBOARD;
                  else if (v == 32'd2) cls_next = CLS_MOUSE;
                  else if (v == 32'd4 || v == 32'd5) cls_next = CLS_JOYSTICK;
                end else if (app_d != 8'd0) begin
                  if (v == 32'(USAGE_X) || v == 32'(USAGE_Y)) begin
                    if (cls == CLS_JOYSTICK || cls == CLS_MOUSE)
                      slots_next[(v == 32'(USAGE_X)) ? 2'd0 : 2'd1] = uidx[7:0];
                  end else if (v == 32'(USAGE_HAT) && cls == CLS_JOYSTICK) begin
                    slots_next[2] = uidx[7:0];
                  end else if (v == 32'(USAGE_WHEEL) && cls == CLS_MOUSE) begin
                    slots_next[3] = uidx[7:0];
                  end
                end
                uidx_next = uidx + 16'd1;
              end
              TAG_UMIN: uidx_next = uidx - ({8'd0, v[7:0]} - 16'd1);
              TAG_UMAX: uidx_next = uidx + v[15:0];
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end

    if (!stop && last) begin
      stop = 1'b1;
      st = is_usable(cls_next, flags_next) ? ST_OK : ST_INCOMPLETE;
    end
    if (stop && !last) fin_next = 1'b1;

    lenb = ({1'b0, bits_next} + 17'd7) >> 3;
    summ.status = st;
    summ.byte_pos = bytepos_next;
    summ.len = (lenb > 17'd255) ? 8'd255 : lenb[7:0];
    summ.cls = cls_next;
    summ.rid = rid_next;
    summ.btotal = btotal_next;
    summ.err = err;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && ((fin && last) || (!fin && last)))) begin
      in_phase <= 1'b0; hdr <= '0; left <= '0; have <= '0; pval <= '0;
      app_d <= '0; pl_d <= '0; skip_d <= '0; nest_d <= '0;
      rsize <= '0; rcount <= '0; bits <= '0; uidx <= '0; lmin <= '0; lmax <= '0;
      flags <= '0; slots <= {4{NO_SLOT}}; cls <= CLS_NONE; rid <= '0; btotal <= '0;
      recs <= '0; bval <= '0; bpos <= '0; bytepos <= '0; fin <= 1'b0;
    end else if (accept && !fin) begin
      in_phase <= in_phase_next; hdr <= hdr_next; left <= left_next;
      have <= have_next; pval <= pval_next; app_d <= app_d_next; pl_d <= pl_d_next;
      skip_d <= skip_d_next; nest_d <= nest_d_next; rsize <= rsize_next;
      rcount <= rcount_next; bits <= bits_next; uidx <= uidx_next;
      lmin <= lmin_next; lmax <= lmax_next; flags <= flags_next;
      slots <= slots_next; cls <= cls_next; rid <= rid_next;
      btotal <= btotal_next; recs <= recs_next; bval <= bval_next;
      bpos <= bpos_next; bytepos <= bytepos_next; fin <= fin_next;
    end
  end

  hidrd_emit #(.BUTTONS(BUTTONS)) u_emit (
    .clk(clk), .rst(rst), .start(accept && !fin && stop), .summary(summ),
    .recs(recs_next), .bvalid(bval_next), .bpos(bpos_next), .busy(busy),
    .valid(out_valid), .ready(out_ready), .record_kind(record_kind),
    .button_index(button_index), .bit_offset(bit_offset), .field_size(field_size),
    .logical_min(logical_min), .logical_max(logical_max), .status(status),
    .device_type(device_type), .rep_id(rep_id), .button_bits(button_bits),
    .error_item(error_item), .last_record(last_record)
  );
endmodule
`default_nettype wire

// ===== rtl/hidrd_emit.sv =====
`default_nettype none
module hidrd_emit #(
  parameter int BUTTONS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire hidrd_pkg::summary_t       summary,
  input  wire hidrd_pkg::field_rec_t [3:0] recs,
  input  wire logic [BUTTONS-1:0]        bvalid,
  input  wire logic [BUTTONS-1:0][15:0]  bpos,
  output logic                           busy,
  output logic                           valid,
  input  wire logic                      ready,
  output logic [2:0]                     record_kind,
  output logic [3:0]                     button_index,
  output logic [15:0]                    bit_offset,
  output logic [7:0]                     field_size,
  output logic [15:0]                    logical_min,
  output logic [15:0]                    logical_max,
  output logic [2:0]                     status,
  output logic [1:0]                     device_type,
  output logic [7:0]                     rep_id,
  output logic [7:0]                     button_bits,
  output logic [8:0]                     error_item,
  output logic                           last_record
);
  import hidrd_pkg::*;

  localparam int NSEL = 5 + BUTTONS;
  localparam int SW = $clog2(NSEL);
  localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  summary_t                   sum_q;
  field_rec_t [3:0]           recs_q;
  logic [BUTTONS-1:0]         bval_q;
  logic [BUTTONS-1:0][15:0]   bpos_q;
  logic [NSEL-1:0]            pend;
  logic [NSEL-1:0]            pend_next;
  logic [SW-1:0]              sel;
  logic                       found;
  logic                       more;
  logic                       take;

  assign busy = |pend;
  assign take = !valid || ready;

  always_comb begin
    sel = '0;
    found = 1'b0;
    for (int i = 0; i < NSEL; i++) begin
      if (pend[i] && !found) begin
        sel = SW'(i);
        found = 1'b1;
      end
    end
    pend_next = pend;
    if (found) begin
      pend_next[sel] = 1'b0;
    end
    more = |pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      valid <= 1'b0;
    end else if (start) begin
      sum_q <= summary;
      recs_q <= recs;
      bval_q <= bvalid;
      bpos_q <= bpos;
      pend <= {bvalid, recs[3].valid, recs[2].valid, recs[1].valid, recs[0].valid, 1'b1};
      if (ready) begin
        valid <= 1'b0;
      end
    end else if (take) begin
      valid <= found;
      if (found) begin
        pend <= pend_next;
        last_record <= !more;
        record_kind <= '0;
        button_index <= '0;
        bit_offset <= '0;
        field_size <= '0;
        logical_min <= '0;
        logical_max <= '0;
        status <= '0;
        device_type <= '0;
        rep_id <= '0;
        button_bits <= '0;
        error_item <= '0;
        if (sel == '0) begin
          record_kind <= KIND_SUMMARY;
          bit_offset <= sum_q.byte_pos;
          field_size <= sum_q.len;
          status <= sum_q.status;
          device_type <= sum_q.cls;
          rep_id <= sum_q.rid;
          button_bits <= sum_q.btotal;
          error_item <= sum_q.err;
        end else if (sel < SW'(5)) begin
          record_kind <= 3'(sel);
          bit_offset <= recs_q[2'(sel - SW'(1))].offset;
          field_size <= recs_q[2'(sel - SW'(1))].size;
          logical_min <= recs_q[2'(sel - SW'(1))].lmin;
          logical_max <= recs_q[2'(sel - SW'(1))].lmax;
        end else begin
          record_kind <= KIND_BUTTON;
          button_index <= 4'(sel - SW'(5));
          bit_offset <= bpos_q[BW'(sel - SW'(5))];
          field_size <= 8'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire
